// ===== hdl/dwsg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dwsg_pkg;

    localparam int POINT_COUNT   = 256;
    localparam int SCREEN_HEIGHT = 170;
    localparam int CENTER        = SCREEN_HEIGHT / 2;
    localparam int MAX_CYCLES    = 20;
    localparam int FULL_SCALE_MV = 3300;
    localparam int Q15_SHIFT     = 15;

    // floor(mv * CENTER / FULL_SCALE_MV) == (mv * HALF_RECIP) >> HALF_SHIFT for mv <= 3300
    localparam int          HALF_SHIFT = 32;
    localparam logic [26:0] HALF_RECIP = 27'd110628010;

    localparam int SINE_ROM_DEPTH = 65;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_TRI    = 2'd1,
        WAVE_SAW    = 2'd2,
        WAVE_SQUARE = 2'd3
    } t_wave_mode;

    typedef enum logic [1:0] {
        REG_WAVE_MODE     = 2'd0,
        REG_CYCLE_REQUEST = 2'd1,
        REG_AMPLITUDE_MV  = 2'd2
    } t_reg_index;

    typedef struct packed {
        t_wave_mode  mode;
        logic [15:0] cycles;
        logic [11:0] amp_mv;
    } t_cfg;

    typedef struct packed {
        t_wave_mode  mode;
        logic [7:0]  phase;
        logic [11:0] amp_mv;
        logic        flat;
    } t_phase;

    typedef struct packed {
        logic [6:0]         half;
        logic signed [16:0] level;
        logic               flat;
    } t_shape;

    typedef struct packed {
        logic signed [24:0] offset;
        logic               flat;
    } t_offset;

    typedef logic [15:0] t_sine_rom [0:SINE_ROM_DEPTH-1];

    function automatic longint f_mul_q16(longint a, longint b);
        return (a * b) / 65536;
    endfunction

    // Q15 sine magnitude for a quarter-wave position in Q16
    function automatic longint f_sine_quarter(longint q16);
        longint q2;
        longint t;
        longint s30;
        longint m;
        q2  = f_mul_q16(q16, q16);
        t   = 64'sd172272;
        t   = -64'sd5026995 + f_mul_q16(t, q2);
        t   = 64'sd85569306 + f_mul_q16(t, q2);
        t   = -64'sd693598668 + f_mul_q16(t, q2);
        t   = 64'sd1686629713 + f_mul_q16(t, q2);
        s30 = f_mul_q16(t, q16);
        if (s30 < 0) s30 = 0;
        m = (s30 + 16384) / 32768;
        if (m > 32768) m = 32768;
        return m;
    endfunction

    function automatic t_sine_rom f_build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i < SINE_ROM_DEPTH; i++) begin
            rom[i] = 16'(f_sine_quarter(longint'(i) * 1024));
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_sine_rom();

endpackage

`default_nettype wire

// ===== hdl/display_waveform_sample_generator_top.sv =====
// Throughput: one request per cycle unless the output stalls, through a four-stage
// pipeline: phase multiply, half amplitude multiply with sine table lookup, offset
// multiply, clamp.
// Reset (synchronous, active low) empties the pipeline and clears the mode,
// cycle and amplitude registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module display_waveform_sample_generator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_point_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_sample_height,
    output logic             o_no_signal
);

    dwsg_pkg::t_cfg   r_cfg;
    dwsg_pkg::t_phase phase_data;
    dwsg_pkg::t_shape shape_data;
    logic             phase_valid;
    logic             phase_ready;
    logic             shape_valid;
    logic             shape_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= dwsg_pkg::WAVE_SINE;
            r_cfg.cycles <= 16'd0;
            r_cfg.amp_mv <= 12'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                dwsg_pkg::REG_WAVE_MODE: begin
                    r_cfg.mode <= dwsg_pkg::t_wave_mode'(i_cfg_wdata[1:0]);
                end
                dwsg_pkg::REG_CYCLE_REQUEST: begin
                    r_cfg.cycles <= i_cfg_wdata;
                end
                dwsg_pkg::REG_AMPLITUDE_MV: begin
                    r_cfg.amp_mv <= i_cfg_wdata[11:0];
                end
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    dwsg_phase u_phase (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_point_index (i_point_index),
        .o_valid       (phase_valid),
        .i_ready       (phase_ready),
        .o_data        (phase_data)
    );

    dwsg_shape u_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (phase_valid),
        .o_ready (phase_ready),
        .i_data  (phase_data),
        .o_valid (shape_valid),
        .i_ready (shape_ready),
        .o_data  (shape_data)
    );

    dwsg_height u_height (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (shape_valid),
        .o_ready         (shape_ready),
        .i_data          (shape_data),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_sample_height (o_sample_height),
        .o_no_signal     (o_no_signal)
    );

endmodule

`default_nettype wire

// ===== hdl/dwsg_phase.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dwsg_phase (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dwsg_pkg::t_cfg  i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_point_index,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output dwsg_pkg::t_phase     o_data
);

    logic             r_valid;
    dwsg_pkg::t_phase r_data;
    dwsg_pkg::t_phase n_data;
    logic [4:0]       cyc_clamped;
    logic [12:0]      phase_full;
    logic [11:0]      mv_sat;

    always_comb begin
        cyc_clamped = (i_cfg.cycles > 16'(dwsg_pkg::MAX_CYCLES))
                    ? 5'(dwsg_pkg::MAX_CYCLES) : i_cfg.cycles[4:0];
        mv_sat      = (i_cfg.amp_mv > 12'(dwsg_pkg::FULL_SCALE_MV))
                    ? 12'(dwsg_pkg::FULL_SCALE_MV) : i_cfg.amp_mv;
        // phase fraction is the product modulo the point count
        phase_full  = 13'(i_point_index) * 13'(cyc_clamped);
        n_data.mode   = i_cfg.mode;
        n_data.phase  = phase_full[7:0];
        n_data.amp_mv = mv_sat;
        n_data.flat   = (cyc_clamped == 5'd0) || (mv_sat == 12'd0);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== hdl/dwsg_shape.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dwsg_shape (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire dwsg_pkg::t_phase i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output dwsg_pkg::t_shape      o_data
);

    logic               r_valid;
    dwsg_pkg::t_shape   r_data;
    dwsg_pkg::t_shape   n_data;
    logic [38:0]        half_prod;
    logic [6:0]         half;
    logic [1:0]         quad;
    logic [6:0]         rom_idx;
    logic [15:0]        mag;
    logic signed [10:0] phase_s;
    logic signed [10:0] w_tri;
    logic signed [10:0] w_saw;
    logic signed [16:0] level;

    always_comb begin
        half_prod = 39'(i_data.amp_mv) * 39'(dwsg_pkg::HALF_RECIP);
        half      = half_prod[38:dwsg_pkg::HALF_SHIFT];
        // any nonzero amplitude gives at least one pixel
        if (i_data.amp_mv != 12'd0 && half == 7'd0) begin
            half = 7'd1;
        end

        // fold the phase into a quarter wave
        quad    = i_data.phase[7:6];
        rom_idx = quad[0] ? (7'd64 - 7'(i_data.phase[5:0])) : 7'(i_data.phase[5:0]);
        mag     = dwsg_pkg::SINE_ROM[rom_idx];

        phase_s = 11'(i_data.phase);
        w_tri   = i_data.phase[7] ? ((phase_s <<< 2) - 11'sd768)
                                  : (11'sd256 - (phase_s <<< 2));
        w_saw   = (phase_s <<< 1) - 11'sd256;

        // every shape is scaled to a Q15 level in -1.0..+1.0
        case (i_data.mode)
            dwsg_pkg::WAVE_SINE: begin
                level = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
            dwsg_pkg::WAVE_TRI: begin
                level = 17'(w_tri) <<< 7;
            end
            dwsg_pkg::WAVE_SAW: begin
                level = 17'(w_saw) <<< 7;
            end
            default: begin
                level = i_data.phase[7] ? -17'sd32768 : 17'sd32768;
            end
        endcase

        n_data.half  = half;
        n_data.level = level;
        n_data.flat  = i_data.flat;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== hdl/dwsg_height.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dwsg_height (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire dwsg_pkg::t_shape i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [7:0]            o_sample_height,
    output logic                  o_no_signal
);

    localparam logic signed [24:0] CENTER_Q =
        25'(dwsg_pkg::CENTER) <<< dwsg_pkg::Q15_SHIFT;

    // offset stage
    logic               r_off_valid;
    logic               off_ready;
    dwsg_pkg::t_offset  r_off;
    dwsg_pkg::t_offset  n_off;

    // output stage
    logic               r_out_valid;
    logic [7:0]         r_height;
    logic               r_no_signal;
    logic [7:0]         n_height;
    logic signed [24:0] num;
    logic [9:0]         whole;

    always_comb begin
        n_off.offset = 25'($signed({1'b0, i_data.half})) * 25'(i_data.level);
        n_off.flat   = i_data.flat;
    end

    assign off_ready = !r_out_valid || i_ready;
    assign o_ready   = !r_off_valid || off_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_valid <= 1'b0;
        end else if (o_ready) begin
            r_off_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_off <= n_off;
        end
    end

    always_comb begin
        num   = CENTER_Q + r_off.offset;
        whole = num[24:15];
        if (r_off.flat) begin
            n_height = 8'(dwsg_pkg::CENTER);
        end else if (num < 0) begin
            n_height = 8'd0;
        end else if (whole > 10'(dwsg_pkg::SCREEN_HEIGHT)) begin
            n_height = 8'(dwsg_pkg::SCREEN_HEIGHT);
        end else begin
            n_height = whole[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (off_ready) begin
            r_out_valid <= r_off_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (off_ready && r_off_valid) begin
            r_height    <= n_height;
            r_no_signal <= r_off.flat;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sample_height = r_height;
    assign o_no_signal     = r_no_signal;

endmodule

`default_nettype wire

// ===== tb/tb_display_waveform_sample_generator_top.sv =====
`timescale 1ns / 1ps

module tb_display_waveform_sample_generator_top;

    localparam logic [1:0] REG_SPARE_INDEX = 2'd3;
    localparam longint     SINE_COEF [5] = '{
        64'sd172272, -64'sd5026995, 64'sd85569306, -64'sd693598668, 64'sd1686629713
    };

    typedef struct packed {
        logic [7:0] height;
        logic       flat;
    } t_point_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_point_index = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_sample_height;
    logic        o_no_signal;

    // copy of the register file as the block should hold it
    dwsg_pkg::t_wave_mode shadow_mode = dwsg_pkg::WAVE_SINE;
    logic [15:0]          shadow_cycles = '0;
    logic [11:0]          shadow_amp_mv = '0;

    t_point_result pending_heights [$];
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    int unsigned   n_points_sent = 0;
    int unsigned   n_heights_checked = 0;
    int unsigned   n_settings = 0;
    int unsigned   n_errors = 0;

    display_waveform_sample_generator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_point_index   (i_point_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sample_height (o_sample_height),
        .o_no_signal     (o_no_signal)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb_display_waveform_sample_generator_top: done, errors");
        $finish;
    end

    // Q15 sine magnitude of a quarter-wave position given in Q16, Horner form
    function automatic longint sine_mag_q15(longint pos_q16);
        longint x2;
        longint acc;
        longint s30;
        longint mag;
        x2  = (pos_q16 * pos_q16) / 65536;
        acc = SINE_COEF[0];
        for (int k = 1; k < 5; k++) begin
            acc = SINE_COEF[k] + (acc * x2) / 65536;
        end
        s30 = (acc * pos_q16) / 65536;
        if (s30 < 0) s30 = 0;
        mag = (s30 + 16384) / 32768;
        return (mag > 32768) ? 64'sd32768 : mag;
    endfunction

    function automatic t_point_result waveform_height(logic [7:0] idx);
        t_point_result res;
        longint cyc;
        longint mv;
        longint half;
        longint r;
        longint quad;
        longint u;
        longint pos;
        longint off;
        longint num;
        longint den;
        longint pts;
        longint ctr;
        pts = dwsg_pkg::POINT_COUNT;
        ctr = dwsg_pkg::CENTER;
        cyc = (shadow_cycles > dwsg_pkg::MAX_CYCLES) ? dwsg_pkg::MAX_CYCLES : shadow_cycles;
        mv  = (shadow_amp_mv > dwsg_pkg::FULL_SCALE_MV)
            ? dwsg_pkg::FULL_SCALE_MV : shadow_amp_mv;
        half = mv * ctr / dwsg_pkg::FULL_SCALE_MV;
        if (mv > 0 && half == 0) half = 1;
        if (cyc == 0 || half == 0) begin
            res.height = 8'(dwsg_pkg::CENTER);
            res.flat   = 1'b1;
            return res;
        end
        r = (longint'(idx) * cyc) % pts;
        case (shadow_mode)
            dwsg_pkg::WAVE_SINE: begin
                quad = (4 * r) / pts;
                u    = (4 * r) % pts;
                pos  = (quad == 1 || quad == 3) ? (pts - u) : u;
                off  = half * sine_mag_q15((pos * 65536) / pts);
                if (quad >= 2) off = -off;
                num = ctr * 32768 + off;
                den = 32768;
            end
            dwsg_pkg::WAVE_TRI: begin
                num = ctr * pts + half * ((2 * r < pts) ?
                      (pts - 4 * r) : (4 * r - 3 * pts));
                den = pts;
            end
            dwsg_pkg::WAVE_SAW: begin
                num = ctr * pts + half * (2 * r - pts);
                den = pts;
            end
            default: begin
                num = (2 * r < pts) ? (ctr + half) : (ctr - half);
                den = 1;
            end
        endcase
        if (num < 0) res.height = '0;
        else if (num / den > dwsg_pkg::SCREEN_HEIGHT) res.height = 8'(dwsg_pkg::SCREEN_HEIGHT);
        else res.height = 8'(num / den);
        res.flat = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // predict on each accepted request, then compare each accepted height
    t_point_result want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pending_heights.push_back(waveform_height(i_point_index));
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_heights.size() == 0) begin
                    $error("unexpected result: sample_height %0d, no_signal %0b",
                           o_sample_height, o_no_signal);
                    n_errors++;
                end else begin
                    want = pending_heights.pop_front();
                    n_heights_checked++;
                    if (o_sample_height !== want.height) begin
                        $error("sample_height: expected %0d, got %0d",
                               want.height, o_sample_height);
                        n_errors++;
                    end
                    if (o_no_signal !== want.flat) begin
                        $error("no_signal: expected %0b, got %0b", want.flat, o_no_signal);
                        n_errors++;
                    end
                end
            end
        end
    end

    task automatic send_point(input logic [7:0] idx);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_point_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        n_points_sent++;
    endtask

    // drop valid and hold until every predicted height has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_heights.size() != 0);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            dwsg_pkg::REG_WAVE_MODE:     shadow_mode = dwsg_pkg::t_wave_mode'(data[1:0]);
            dwsg_pkg::REG_CYCLE_REQUEST: shadow_cycles = data;
            dwsg_pkg::REG_AMPLITUDE_MV:  shadow_amp_mv = data[11:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] mode_w, input logic [15:0] cycles_w,
                              input logic [15:0] amp_w);
        wait_for_results();
        cfg_write(dwsg_pkg::REG_WAVE_MODE, mode_w);
        cfg_write(dwsg_pkg::REG_CYCLE_REQUEST, cycles_w);
        cfg_write(dwsg_pkg::REG_AMPLITUDE_MV, amp_w);
        i_cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic test_flat_line();
        send_point(8'd128);
        set_config(16'(dwsg_pkg::WAVE_SINE), 16'd0, 16'd3300);
        send_point(8'd0);
        send_point(8'd255);
        set_config(16'(dwsg_pkg::WAVE_SAW), 16'd20, 16'd0);
        send_point(8'd77);
    endtask

    task automatic test_waveforms();
        dwsg_pkg::t_wave_mode m;
        m = dwsg_pkg::WAVE_SINE;
        for (int k = 0; k < 4; k++) begin
            set_config(16'(m), 16'd1, 16'd3300);
            for (int q = 0; q < 4; q++) send_point(8'(q * 64));
            m = m.next();
        end
    endtask

    task automatic test_limits();
        // all-ones writes: square, cycles clamp, amplitude saturation
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_point(8'd13);
        // tiny amplitude still gives one pixel of swing
        set_config(16'(dwsg_pkg::WAVE_SINE), 16'd20, 16'd1);
        send_point(8'd3);
    endtask

    task automatic test_spare_index();
        set_config(16'(dwsg_pkg::WAVE_TRI), 16'd7, 16'd1650);
        wait_for_results();
        cfg_write(REG_SPARE_INDEX, 16'hFFFF);
        i_cfg_wr_en <= 1'b0;
        send_point(8'd255);
        send_point(8'd37);
    endtask

    function automatic logic [15:0] pick_cycles();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd20;
            3:       return 16'd21;
            4:       return 16'hFFFF;
            5, 6:    return 16'($urandom_range(1, 20));
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [15:0] pick_amp();
        logic [11:0] mv;
        case ($urandom_range(7))
            0:       mv = 12'd0;
            1:       mv = 12'd1;
            2:       mv = 12'd3300;
            3:       mv = 12'($urandom_range(3301, 4095));
            4:       mv = 12'hFFF;
            default: mv = 12'($urandom_range(1, 3300));
        endcase
        return {4'($urandom_range(15)), mv};
    endfunction

    task automatic test_random_traffic();
        int n;
        for (int stage = 0; stage < 3; stage++) begin
            send_idle_pct = (stage == 0) ? 7 : (stage == 1) ? 87 : 0;
            recv_idle_pct = (stage == 0) ? 87 : (stage == 1) ? 7 : 0;
            for (int s = 0; s < 10; s++) begin
                set_config({14'($urandom_range(16'h3FFF)), 2'($urandom_range(3))},
                           pick_cycles(), pick_amp());
                n = $urandom_range(40, 80);
                for (int k = 0; k < n; k++) send_point(8'($urandom_range(255)));
            end
        end
        wait_for_results();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_flat_line();
        test_waveforms();
        test_limits();
        test_spare_index();
        test_random_traffic();
        repeat (8) @(posedge i_clk);
        $display("tb_display_waveform_sample_generator_top: %0d points over %0d settings,",
                 n_points_sent, n_settings);
        $display("  %0d heights checked; all four shapes, flat line, clamps and stalls",
                 n_heights_checked);
        if (n_errors == 0 && pending_heights.size() == 0) begin
            $display("tb_display_waveform_sample_generator_top: done, clean");
        end else begin
            $display("tb_display_waveform_sample_generator_top: done, errors");
        end
        $finish;
    end

endmodule
